### design/rgbf_pkg.sv
// Shared widths, operation codes and sequencer states of the RGB fade engine.
package rgbf_pkg;

    // Default number of fraction bits of a channel level
    localparam int unsigned FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int unsigned OP_W    = 3;
    localparam int unsigned VALUE_W = 9;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned OUT_W   = 8;

    // Operation codes; the two unused top codes do nothing but report
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_SET      = 3'd1,
        OP_FADE_TO  = 3'd2,
        OP_ADD      = 3'd3,
        OP_OFF      = 3'd4,
        OP_SET_FADE = 3'd5
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHAN,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### design/rgbf_cmd_if.sv
// Command and result channels of the RGB fade engine.
interface rgbf_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [rgbf_pkg::OP_W-1:0]         operation;
    logic signed [rgbf_pkg::VALUE_W-1:0] red_value;
    logic signed [rgbf_pkg::VALUE_W-1:0] green_value;
    logic signed [rgbf_pkg::VALUE_W-1:0] blue_value;
    logic [rgbf_pkg::TICKS_W-1:0]      fade_ticks;
    logic                              fade_flag;

    modport source (
        output valid, operation, red_value, green_value, blue_value, fade_ticks, fade_flag,
        input  ready
    );
    modport sink (
        input  valid, operation, red_value, green_value, blue_value, fade_ticks, fade_flag,
        output ready
    );
endinterface

interface rgbf_res_if;
    logic                          valid;
    logic                          ready;
    logic [rgbf_pkg::OUT_W-1:0]    red_level;
    logic [rgbf_pkg::OUT_W-1:0]    green_level;
    logic [rgbf_pkg::OUT_W-1:0]    blue_level;
    logic                          any_fading;

    modport source (
        output valid, red_level, green_level, blue_level, any_fading,
        input  ready
    );
    modport sink (
        input  valid, red_level, green_level, blue_level, any_fading,
        output ready
    );
endinterface

### design/rgbf_div.sv
// Restoring divider, one quotient bit per cycle, shared by all three channels.
module rgbf_div #(
    parameter int unsigned NUM_W = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [NUM_W-1:0]                  i_num,
    input  logic [rgbf_pkg::TICKS_W-1:0]      i_den,
    output logic                              o_done,
    output logic [NUM_W-1:0]                  o_quot
);
    import rgbf_pkg::*;

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [TICKS_W-1:0] r_rem;
    logic [TICKS_W-1:0] r_den;
    logic [NUM_W-1:0]   r_quot;

    logic [TICKS_W:0]   trial;
    logic [TICKS_W:0]   diff;
    logic               qbit;

    // Shift in the next dividend bit and try to subtract
    always_comb begin
        trial = {r_rem, r_quot[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // Control: count the quotient bits, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/rgbf_alu.sv
// Channel update unit: applies one operation to the selected channel's state.
module rgbf_alu #(
    parameter int unsigned FRACTION_BITS = rgbf_pkg::FRACTION_BITS_DEF
) (
    input  logic [rgbf_pkg::OP_W-1:0]          i_op,
    input  logic signed [rgbf_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_flag,
    input  logic [FRACTION_BITS+7:0]           i_level,
    input  logic [FRACTION_BITS+7:0]           i_target,
    input  logic signed [FRACTION_BITS+8:0]    i_step,
    input  logic                               i_fading,
    output logic [FRACTION_BITS+7:0]           o_level,
    output logic [FRACTION_BITS+7:0]           o_target,
    output logic                               o_fading,
    output logic [FRACTION_BITS+7:0]           o_div_num,
    output logic                               o_div_neg,
    output logic                               o_div_nz
);
    import rgbf_pkg::*;

    localparam int unsigned LW = FRACTION_BITS + 8;

    // Clamp a widened sum to the level range
    function automatic logic [LW-1:0] sat_level(input logic signed [LW+1:0] s);
        logic [LW-1:0] r;
        if (s[LW+1])
            r = '0;
        else if (s[LW])
            r = '1;
        else
            r = s[LW-1:0];
        return r;
    endfunction

    logic [OUT_W-1:0]     clamped;
    logic [LW-1:0]        pos_lvl;
    logic signed [LW:0]   diff_tick;
    logic signed [LW:0]   diff_fade;
    logic [LW:0]          rem_full;
    logic [LW:0]          fade_abs;
    logic signed [LW:0]   eff;
    logic [LW:0]          mag;
    logic                 snap;
    logic signed [LW:0]   inc;
    logic signed [LW+1:0] sum_tick;
    logic signed [LW+1:0] sum_add;

    // Distances, effective step and sums
    always_comb begin
        clamped   = i_value[VALUE_W-1] ? '0 : i_value[OUT_W-1:0];
        pos_lvl   = {clamped, {FRACTION_BITS{1'b0}}};
        diff_tick = $signed({1'b0, i_target}) - $signed({1'b0, i_level});
        diff_fade = $signed({1'b0, pos_lvl}) - $signed({1'b0, i_level});
        rem_full  = diff_tick[LW] ? -diff_tick : diff_tick;
        fade_abs  = diff_fade[LW] ? -diff_fade : diff_fade;
        // A zero step still moves one LSB toward the target
        if (i_step == '0)
            eff = diff_tick[LW] ? {(LW+1){1'b1}} : (LW+1)'(1);
        else
            eff = i_step;
        mag       = eff[LW] ? -eff : eff;
        snap      = ({1'b0, rem_full[LW-1:0]} < mag);
        inc       = {i_value, {FRACTION_BITS{1'b0}}};
        sum_tick  = $signed({2'b00, i_level}) + $signed({eff[LW], eff});
        sum_add   = $signed({2'b00, i_level}) + $signed({inc[LW], inc});
    end

    // Select the new channel state by operation
    always_comb begin
        o_level   = i_level;
        o_target  = i_target;
        o_fading  = i_fading;
        o_div_num = fade_abs[LW-1:0];
        o_div_neg = diff_fade[LW];
        o_div_nz  = (diff_fade != '0);
        unique case (i_op)
            OP_TICK: begin
                if (i_fading) begin
                    if (snap) begin
                        o_level  = i_target;
                        o_fading = 1'b0;
                    end else begin
                        o_level = sat_level(sum_tick);
                    end
                end
            end
            OP_SET: begin
                o_level  = pos_lvl;
                o_target = pos_lvl;
                o_fading = 1'b0;
            end
            OP_FADE_TO: begin
                o_target = pos_lvl;
            end
            OP_ADD: begin
                o_level = sat_level(sum_add);
            end
            OP_OFF: begin
                o_level = '0;
            end
            OP_SET_FADE: begin
                o_fading = i_flag;
            end
            default: begin
            end
        endcase
    end

endmodule

### design/rgb_linear_fade_engine.sv
// Top level of the RGB fade engine: command sequencer, channel state, result register.
//
//   channel   dir   words
//   i_cmd     in    operation, red/green/blue value, fade ticks, fade flag
//   o_res     out   red/green/blue level, any-fading flag
//
// Channels are processed one after the other through one update unit and one
// restoring divider; a fade_to runs the divider once per channel. A new command
// is taken only once the result of the last one is loaded and the sequencer is
// back in idle. i_cmd.ready is high only while the sequencer is idle.
// A waiting result is held in the output register; the sequencer stalls before
// loading the next one. Synchronous reset clears all levels, targets, steps,
// fading flags and the result valid at once.
module rgb_linear_fade_engine #(
    parameter int unsigned FRACTION_BITS = rgbf_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgbf_cmd_if.sink   i_cmd,
    rgbf_res_if.source o_res
);
    import rgbf_pkg::*;

    localparam int unsigned LW = FRACTION_BITS + 8;
    localparam int unsigned SW = FRACTION_BITS + 9;
    localparam int unsigned NCH = 3;

    // Sequencer
    t_state r_state, n_state;
    logic [1:0] r_ch, n_ch;
    logic       div_start;
    logic       wr_chan;
    logic       wr_step;
    logic       out_load;
    logic       accept;

    // Latched command
    logic [OP_W-1:0]          r_op;
    logic signed [VALUE_W-1:0] r_val [NCH];
    logic [TICKS_W-1:0]       r_ticks;
    logic                     r_flag;

    // Channel state
    logic [LW-1:0]        r_level  [NCH];
    logic [LW-1:0]        r_target [NCH];
    logic signed [SW-1:0] r_step   [NCH];
    logic                 r_fading [NCH];

    // Divider side info
    logic r_div_neg;
    logic r_div_nz;

    // Result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_red;
    logic [OUT_W-1:0] r_green;
    logic [OUT_W-1:0] r_blue;
    logic             r_any;

    // Unit connections
    logic [LW-1:0] alu_level;
    logic [LW-1:0] alu_target;
    logic          alu_fading;
    logic [LW-1:0] alu_div_num;
    logic          alu_div_neg;
    logic          alu_div_nz;
    logic          div_done;
    logic [LW-1:0] div_quot;
    logic [LW-1:0] quot_fix;
    logic signed [SW-1:0] step_new;

    rgbf_alu #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_alu (
        .i_op      (r_op),
        .i_value   (r_val[r_ch]),
        .i_flag    (r_flag),
        .i_level   (r_level[r_ch]),
        .i_target  (r_target[r_ch]),
        .i_step    (r_step[r_ch]),
        .i_fading  (r_fading[r_ch]),
        .o_level   (alu_level),
        .o_target  (alu_target),
        .o_fading  (alu_fading),
        .o_div_num (alu_div_num),
        .o_div_neg (alu_div_neg),
        .o_div_nz  (alu_div_nz)
    );

    rgbf_div #(
        .NUM_W(LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (alu_div_num),
        .i_den   (r_ticks),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign accept = i_cmd.valid && i_cmd.ready;

    // Force a zero quotient to one LSB toward the target, then apply the sign
    always_comb begin
        quot_fix = (div_quot == '0 && r_div_nz) ? LW'(1) : div_quot;
        step_new = r_div_neg ? -$signed({1'b0, quot_fix}) : $signed({1'b0, quot_fix});
    end

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // Advance through the channels
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        div_start   = 1'b0;
        wr_chan     = 1'b0;
        wr_step     = 1'b0;
        out_load    = 1'b0;
        i_cmd.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = ST_CHAN;
                    n_ch    = '0;
                end
            end
            ST_CHAN: begin
                wr_chan = 1'b1;
                if (r_op == OP_FADE_TO) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else if (r_ch == 2'(NCH - 1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    wr_step = 1'b1;
                    if (r_ch == 2'(NCH - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = ST_CHAN;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Latch the command word; a fade with zero ticks becomes a set
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_cmd.operation == OP_FADE_TO && i_cmd.fade_ticks == '0)
                r_op <= OP_SET;
            else
                r_op <= i_cmd.operation;
            r_val[0] <= i_cmd.red_value;
            r_val[1] <= i_cmd.green_value;
            r_val[2] <= i_cmd.blue_value;
            r_ticks  <= i_cmd.fade_ticks;
            r_flag   <= i_cmd.fade_flag;
        end
    end

    // Capture divider sign info when a division starts
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_div_neg <= alu_div_neg;
            r_div_nz  <= alu_div_nz;
        end
    end

    // Update the selected channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_level[c]  <= '0;
                r_target[c] <= '0;
                r_step[c]   <= '0;
                r_fading[c] <= 1'b0;
            end
        end else begin
            if (wr_chan) begin
                r_level[r_ch]  <= alu_level;
                r_target[r_ch] <= alu_target;
                r_fading[r_ch] <= alu_fading;
            end
            if (wr_step) begin
                r_step[r_ch]   <= step_new;
                r_fading[r_ch] <= r_div_nz;
            end
        end
    end

    // Result valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_red   <= r_level[0][LW-1 -: OUT_W];
            r_green <= r_level[1][LW-1 -: OUT_W];
            r_blue  <= r_level[2][LW-1 -: OUT_W];
            r_any   <= r_fading[0] || r_fading[1] || r_fading[2];
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.red_level   = r_red;
    assign o_res.green_level = r_green;
    assign o_res.blue_level  = r_blue;
    assign o_res.any_fading  = r_any;

endmodule
